### hdl/ukt_pkg.sv
// shared types, codes and constants for the unordered key table
`default_nettype none

package ukt_pkg;

    // default table depth
    localparam int DEF_CAPACITY = 32;

    // fixed field widths
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // removal modes
    localparam logic RM_MOVE_LAST = 1'b0;
    localparam logic RM_SHIFT     = 1'b1;

    // request payload
    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key;
    } ukt_req_t;

    // response payload
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } ukt_rsp_t;

endpackage

`default_nettype wire

### hdl/unordered_key_table_unit.sv
// unordered key table: one key memory, a linear search and a copy sequencer
// insert and lookup scan the stored entries in order until a match or the fill count is reached
// remove then copies the last entry into the freed slot (move last) or each later entry down one slot (shift)
// a new command is accepted only in idle, so each finishes before the next; the key memory has a single read port
// a finished response waits in the output register while the next command runs
// reset clears fill count, removal mode and handshake state; the memory is not cleared
`default_nettype none

module unordered_key_table_unit #(
    parameter int CAPACITY = ukt_pkg::DEF_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire ukt_pkg::ukt_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output ukt_pkg::ukt_rsp_t     rsp,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data
);
    import ukt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_COPY   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // key memory
    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wdata;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mode_reg, mode_next;
    logic             pend_reg, pend_next;
    logic             cpend_reg, cpend_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload state
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_pos_reg, res_pos_next;
    logic [CNT_W-1:0]    src_reg, src_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic [IDX_W-1:0]    wdst_reg, wdst_next;
    ukt_rsp_t            rsp_reg, rsp_next;

    logic req_xfer;
    logic hit;
    logic [CNT_W-1:0] last_idx;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign hit       = pend_reg && (rd_data_reg == key_reg);
    assign last_idx  = count_reg - CNT_W'(1);

    // next state
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        mode_next       = cfg_we ? cfg_data : mode_reg;
        pend_next       = 1'b0;
        cpend_next      = 1'b0;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        src_next        = src_reg;
        end_next        = end_reg;
        wdst_next       = wdst_reg;
        rsp_next        = rsp_reg;
        mem_raddr       = scan_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd_next  = req.command;
                    key_next  = $unsigned(req.key);
                    scan_next = '0;
                    if (req.command == CMD_INSERT || req.command == CMD_LOOKUP ||
                        req.command == CMD_REMOVE)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_pos_next    = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_SEARCH:
            begin
                // compare last read, else issue next read or finish
                if (hit || scan_reg == count_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_pos_next    = '0;
                    state_next      = S_DONE;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_PRESENT;
                                res_pos_next    = pend_idx_reg;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                res_status_next = ST_OK;
                                res_pos_next    = count_reg[IDX_W-1:0];
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                res_pos_next    = pend_idx_reg;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                res_pos_next    = pend_idx_reg;
                                count_next      = last_idx;
                                end_next        = last_idx;
                                src_next        = (mode_reg == RM_SHIFT) ?
                                    (CNT_W'(pend_idx_reg) + CNT_W'(1)) : last_idx;
                                state_next      = S_COPY;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
            end

            S_COPY:
            begin
                // write back the entry read in the previous cycle
                mem_raddr = src_reg[IDX_W-1:0];
                mem_waddr = wdst_reg;
                mem_wdata = rd_data_reg;
                mem_we    = cpend_reg;
                if (src_reg <= end_reg)
                begin
                    cpend_next = 1'b1;
                    wdst_next  = (mode_reg == RM_SHIFT) ?
                        IDX_W'(src_reg - CNT_W'(1)) : res_pos_reg;
                    src_next   = src_reg + CNT_W'(1);
                    if (mode_reg == RM_MOVE_LAST)
                    begin
                        end_next = '0;
                        src_next = CNT_W'(1);
                    end
                end
                else if (!cpend_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_status_reg;
                    rsp_next.position    = POS_W'(res_pos_reg);
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= RM_MOVE_LAST;
            pend_reg      <= 1'b0;
            cpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            cpend_reg     <= cpend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        src_reg        <= src_next;
        end_reg        <= end_next;
        wdst_reg       <= wdst_next;
        rsp_reg        <= rsp_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !(mem_we && hit && cmd_reg != CMD_INSERT))
        else $error("memory written by a non-insert search");

    a_copy_after_decrement: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> count_reg < CNT_W'(CAPACITY))
        else $error("copy running without a decremented count");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> state_reg != S_IDLE)
        else $error("request transfer did not start work");

    a_full_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == COUNT_W'(CAPACITY))
        else $error("table full reported below capacity");

endmodule

`default_nettype wire
